>>> rtl/ifec_pkg.sv
// Shared constants, types and the CRC-32 table for the interleaved XOR parity encoder.
// Used by every module of the block; depends on nothing.
package ifec_pkg;

  localparam int unsigned MaxLanes     = 8;
  localparam int unsigned LaneW        = 3;
  localparam int unsigned WordBytes    = 8;
  localparam int unsigned MaxPayload   = 256;
  localparam int unsigned AccRows      = MaxPayload / WordBytes;
  localparam int unsigned RowW         = 5;
  localparam int unsigned AddrW        = LaneW + RowW;
  localparam int unsigned BankDepth    = MaxLanes * AccRows;
  localparam logic [31:0] CrcPoly      = 32'hEDB88320;

  // Configuration register indexes.
  localparam logic CfgLaneCount   = 1'b0;
  localparam logic CfgGroupLength = 1'b1;

  // Output packet kinds.
  localparam logic KindData   = 1'b0;
  localparam logic KindParity = 1'b1;

  // Input operations.
  localparam logic OpWord  = 1'b0;
  localparam logic OpFlush = 1'b1;

  // Control for one byte bank of the accumulator memory.
  typedef struct packed {
    logic             rd_en;
    logic             wr_en;
    logic             wr_zero;
    logic             clr_en;
    logic [AddrW-1:0] addr;
  } bank_ctrl_t;

  typedef logic [255:0][31:0] crc_tab_t;

  // Byte-wise CRC-32 table, built at elaboration.
  function automatic crc_tab_t crc_tab_gen();
    crc_tab_t t;
    logic [31:0] c;
    for (int v = 0; v < 256; v++) begin
      c = 32'(v);
      for (int k = 0; k < 8; k++) begin
        c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
      end
      t[v] = c;
    end
    return t;
  endfunction

  localparam crc_tab_t CrcTab = crc_tab_gen();

  // Mask that keeps the low n bytes of a word.
  function automatic logic [63:0] byte_mask(logic [3:0] n);
    logic [63:0] m;
    m = '0;
    for (int i = 0; i < 8; i++) begin
      if (4'(i) < n) begin
        m[8*i +: 8] = 8'hFF;
      end
    end
    return m;
  endfunction

endpackage

>>> rtl/ifec_byte_bank.sv
// One byte lane of the lane accumulator memory: read, XOR-merge and write back.
// Depends on ifec_pkg for the address width and control struct.
module ifec_byte_bank (
  input  logic                  clk_i,
  input  ifec_pkg::bank_ctrl_t  ctrl_i,
  input  logic [7:0]            xor_byte_i,
  output logic [7:0]            rd_byte_o
);

  logic [7:0]                 mem [ifec_pkg::BankDepth];
  logic [7:0]                 rd_q;
  logic [ifec_pkg::AddrW-1:0] addr_q;

  // Read port; the address is kept for the write-back that follows.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd_en) begin
      rd_q   <= mem[ctrl_i.addr];
      addr_q <= ctrl_i.addr;
    end
  end

  // Write port: clearing pass at a given address, otherwise XOR or zero write-back.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.clr_en) begin
      mem[ctrl_i.addr] <= '0;
    end else if (ctrl_i.wr_en) begin
      mem[addr_q] <= ctrl_i.wr_zero ? 8'h00 : (rd_q ^ xor_byte_i);
    end
  end

  assign rd_byte_o = rd_q;

endmodule

>>> rtl/ifec_crc.sv
// Word update of the reflected CRC-32: folds the low n bytes of a word into the state.
// Depends on ifec_pkg for the byte table.
module ifec_crc (
  input  logic [31:0] crc_i,
  input  logic [63:0] data_i,
  input  logic [3:0]  nbytes_i,
  output logic [31:0] crc_o
);

  // One table step per valid byte, first byte in the low bits.
  always_comb begin
    logic [31:0] c;
    c = crc_i;
    for (int i = 0; i < 8; i++) begin
      if (4'(i) < nbytes_i) begin
        c = {8'h00, c[31:8]} ^ ifec_pkg::CrcTab[c[7:0] ^ data_i[8*i +: 8]];
      end
    end
    crc_o = c;
  end

endmodule

>>> rtl/interleaved_xor_parity_fec_encoder.sv
// Top level of the interleaved XOR parity encoder.
// Depends on ifec_pkg, ifec_byte_bank and ifec_crc.
//
// Input requests (in_valid_i / in_stall_o) carry payload words or a flush.
// Every payload word is echoed on the output channel (out_valid_o /
// out_stall_i); the last word of a packet carries the header fields. Packets
// are dealt round-robin over lanes, and each lane XORs its group's payloads
// into a memory split into eight byte banks that work side by side. When a
// group fills, its parity packet is sent before the next packet's first
// word, or on a flush request.
// A payload word goes through accept, bank read, then XOR write-back and
// output, as the read-modify-write of the byte banks demands; input is
// stalled until the word is done. Each parity output word takes a bank read,
// then output and clear, and input is stalled for the whole burst.
// After reset the accumulator memory is cleared row by row, and in_stall_o
// stays high during that pass. Configuration writes are taken at any time.
// When the receiver stalls, the output register holds its word and the block
// waits before producing the next one.
module interleaved_xor_parity_fec_encoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        op_i,
  input  logic [63:0] word_data_i,
  input  logic [3:0]  byte_count_i,
  input  logic        end_of_packet_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        packet_kind_o,
  output logic [63:0] out_data_o,
  output logic [3:0]  out_bytes_o,
  output logic        packet_end_o,
  output logic [31:0] sequence_res_o,
  output logic [2:0]  lane_id_o,
  output logic [15:0] lane_group_index_o,
  output logic [7:0]  position_in_group_o,
  output logic [7:0]  group_size_out_o,
  output logic [8:0]  payload_length_o,
  output logic [31:0] payload_crc_o
);

  localparam int unsigned LW = ifec_pkg::LaneW;
  localparam int unsigned RW = ifec_pkg::RowW;
  localparam int unsigned NL = ifec_pkg::MaxLanes;
  localparam int unsigned NB = ifec_pkg::WordBytes;

  typedef enum logic [5:0] {
    S_CLEAR  = 6'b000001,
    S_IDLE   = 6'b000010,
    S_PREAD  = 6'b000100,
    S_PEMIT  = 6'b001000,
    S_DREAD  = 6'b010000,
    S_DWRITE = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic [ifec_pkg::AddrW-1:0] clr_cnt_q, clr_cnt_d;
  logic [3:0]  lane_count_q;
  logic [7:0]  group_length_q;
  logic        in_packet_q, in_packet_d;
  logic        pend_data_q, pend_data_d;
  logic        parity_waiting_q, parity_waiting_d;
  logic [8:0]  meta_len_q, meta_len_d;
  logic [LW-1:0] meta_lane_q, meta_lane_d;
  logic [15:0] meta_grp_q, meta_grp_d;
  logic [LW-1:0] next_lane_q, next_lane_d;
  logic [LW-1:0] cur_lane_q, cur_lane_d;
  logic [31:0] seq_q, seq_d;
  logic [31:0] crc_q, crc_d;
  logic [8:0]  pos_q, pos_d;
  logic [63:0] item_data_q, item_data_d;
  logic [3:0]  item_bytes_q, item_bytes_d;
  logic        item_eop_q, item_eop_d;
  logic [3:0]  n_q, n_d;
  logic [RW-1:0] prow_q, prow_d;
  logic [8:0]  longest_q [NL];
  logic [8:0]  longest_d [NL];
  logic [7:0]  filled_q [NL];
  logic [7:0]  filled_d [NL];
  logic [15:0] grp_q [NL];
  logic [15:0] grp_d [NL];

  // Output register.
  logic        out_valid_q, out_valid_d;
  logic        kind_q, kind_d;
  logic [63:0] odata_q, odata_d;
  logic [3:0]  obytes_q, obytes_d;
  logic        oend_q, oend_d;
  logic [31:0] oseq_q, oseq_d;
  logic [2:0]  olane_q, olane_d;
  logic [15:0] ogrp_q, ogrp_d;
  logic [7:0]  opos_q, opos_d;
  logic [7:0]  ogsize_q, ogsize_d;
  logic [8:0]  olen_q, olen_d;
  logic [31:0] ocrc_q, ocrc_d;
  logic        out_load;

  ifec_pkg::bank_ctrl_t bank_ctrl [NB];
  logic [7:0]  bank_xor [NB];
  logic [7:0]  bank_rd [NB];
  logic [63:0] acc_word;

  logic [31:0] crc_in_data_sel;
  logic [63:0] crc_data;
  logic [3:0]  crc_n;
  logic [31:0] crc_new;

  logic [3:0]  eff_lanes;
  logic [7:0]  eff_group;
  logic        slot_free;
  logic        in_accept;
  logic [63:0] item_masked;

  // Lane index modulo the lane count; a narrow repeated subtraction.
  function automatic logic [2:0] lane_mod(logic [3:0] a, logic [3:0] m);
    logic [3:0] r;
    r = a;
    for (int i = 0; i < 8; i++) begin
      if (r >= m) begin
        r = r - m;
      end
    end
    return r[2:0];
  endfunction

  // Byte banks: the parallel lanes of the accumulator memory.
  for (genvar b = 0; b < NB; b++) begin : g_bank
    ifec_byte_bank u_bank (
      .clk_i      (clk_i),
      .ctrl_i     (bank_ctrl[b]),
      .xor_byte_i (bank_xor[b]),
      .rd_byte_o  (bank_rd[b])
    );
    assign acc_word[8*b +: 8] = bank_rd[b];
  end

  // Shared CRC unit for data and parity words.
  ifec_crc u_crc (
    .crc_i    (crc_q),
    .data_i   (crc_data),
    .nbytes_i (crc_n),
    .crc_o    (crc_new)
  );

  assign crc_in_data_sel = '0;
  assign eff_lanes = (lane_count_q == 4'd0) ? 4'd1 :
                     (lane_count_q > 4'(NL)) ? 4'(NL) : lane_count_q;
  assign eff_group = (group_length_q == 8'd0) ? 8'd1 : group_length_q;
  assign slot_free = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept = in_valid_i && !in_stall_o;
  assign item_masked = item_data_q & ifec_pkg::byte_mask(n_q);

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lane_count_q   <= 4'd1;
      group_length_q <= 8'd4;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ifec_pkg::CfgLaneCount:   lane_count_q   <= cfg_data_i[3:0];
        ifec_pkg::CfgGroupLength: group_length_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sequencer, lane bookkeeping, bank control and output loading.
  always_comb begin
    logic [3:0]  bc;
    logic [8:0]  room;
    logic [3:0]  nn;
    logic [LW-1:0] lane_sel;
    logic [RW-1:0] row0;
    logic [2:0]  bi;
    logic [8:0]  pos_new;
    logic [8:0]  lng_new;
    logic [9:0]  base;
    logic [9:0]  rem;
    logic        plast;
    state_d          = state_q;
    clr_cnt_d        = clr_cnt_q;
    in_packet_d      = in_packet_q;
    pend_data_d      = pend_data_q;
    parity_waiting_d = parity_waiting_q;
    meta_len_d       = meta_len_q;
    meta_lane_d      = meta_lane_q;
    meta_grp_d       = meta_grp_q;
    next_lane_d      = next_lane_q;
    cur_lane_d       = cur_lane_q;
    seq_d            = seq_q;
    crc_d            = crc_q;
    pos_d            = pos_q;
    item_data_d      = item_data_q;
    item_bytes_d     = item_bytes_q;
    item_eop_d       = item_eop_q;
    n_d              = n_q;
    prow_d           = prow_q;
    longest_d        = longest_q;
    filled_d         = filled_q;
    grp_d            = grp_q;
    out_load         = 1'b0;
    kind_d           = kind_q;
    odata_d          = odata_q;
    obytes_d         = obytes_q;
    oend_d           = oend_q;
    oseq_d           = oseq_q;
    olane_d          = olane_q;
    ogrp_d           = ogrp_q;
    opos_d           = opos_q;
    ogsize_d         = ogsize_q;
    olen_d           = olen_q;
    ocrc_d           = ocrc_q;
    crc_data         = item_masked;
    crc_n            = n_q;
    bc               = '0;
    room             = '0;
    nn               = '0;
    lane_sel         = '0;
    row0             = '0;
    bi               = '0;
    pos_new          = pos_q + 9'(n_q);
    lng_new          = '0;
    base             = {2'b00, prow_q, 3'b000};
    rem              = (10'(meta_len_q) > base) ? (10'(meta_len_q) - base) : 10'd0;
    plast            = (10'(meta_len_q) <= base + 10'd8);
    for (int b = 0; b < NB; b++) begin
      bank_ctrl[b] = '0;
      bank_xor[b]  = '0;
    end

    unique case (state_q)
      // Zero the whole accumulator memory, one row of all banks per cycle.
      S_CLEAR: begin
        for (int b = 0; b < NB; b++) begin
          bank_ctrl[b].clr_en = 1'b1;
          bank_ctrl[b].addr   = clr_cnt_q;
        end
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == '1) begin
          state_d = S_IDLE;
        end
      end

      // Take one request; a pending parity goes out before a new packet.
      S_IDLE: begin
        if (in_accept) begin
          item_data_d  = word_data_i;
          item_bytes_d = byte_count_i;
          item_eop_d   = end_of_packet_i;
          if (op_i == ifec_pkg::OpFlush) begin
            pend_data_d = 1'b0;
            if (parity_waiting_q) begin
              state_d = S_PREAD;
            end
          end else if (!in_packet_q && parity_waiting_q) begin
            pend_data_d = 1'b1;
            state_d     = S_PREAD;
          end else begin
            state_d = S_DREAD;
          end
        end
      end

      // Read one row of the parity lane from all banks.
      S_PREAD: begin
        for (int b = 0; b < NB; b++) begin
          bank_ctrl[b].rd_en = 1'b1;
          bank_ctrl[b].addr  = {meta_lane_q, prow_q};
        end
        state_d = S_PEMIT;
      end

      // Send one parity word and clear the row behind it.
      S_PEMIT: begin
        nn       = (rem > 10'd8) ? 4'd8 : rem[3:0];
        crc_data = acc_word & ifec_pkg::byte_mask(nn);
        crc_n    = nn;
        if (slot_free) begin
          for (int b = 0; b < NB; b++) begin
            bank_ctrl[b].wr_en   = 1'b1;
            bank_ctrl[b].wr_zero = 1'b1;
          end
          out_load = 1'b1;
          kind_d   = ifec_pkg::KindParity;
          odata_d  = crc_data;
          obytes_d = nn;
          oend_d   = plast;
          oseq_d   = '0;
          olane_d  = '0;
          ogrp_d   = '0;
          opos_d   = '0;
          ogsize_d = '0;
          olen_d   = '0;
          ocrc_d   = '0;
          if (plast) begin
            oseq_d           = seq_q;
            olane_d          = meta_lane_q;
            ogrp_d           = meta_grp_q;
            ogsize_d         = eff_group;
            olen_d           = meta_len_q;
            ocrc_d           = ~crc_new;
            seq_d            = seq_q + 32'd1;
            crc_d            = '1;
            prow_d           = '0;
            parity_waiting_d = 1'b0;
            state_d          = pend_data_q ? S_DREAD : S_IDLE;
          end else begin
            crc_d   = crc_new;
            prow_d  = prow_q + 1'b1;
            state_d = S_PREAD;
          end
        end
      end

      // Pick the lane, clip the byte count and read the rows the word touches.
      S_DREAD: begin
        if (in_packet_q) begin
          lane_sel = cur_lane_q;
        end else begin
          lane_sel = ({1'b0, next_lane_q} >= eff_lanes) ? '0 : next_lane_q;
        end
        cur_lane_d  = lane_sel;
        in_packet_d = 1'b1;
        bc   = (item_bytes_q > 4'(NB)) ? 4'(NB) : item_bytes_q;
        room = 9'(ifec_pkg::MaxPayload) - pos_q;
        n_d  = (9'(bc) > room) ? room[3:0] : bc;
        row0 = pos_q[7:3];
        for (int b = 0; b < NB; b++) begin
          bank_ctrl[b].rd_en = 1'b1;
          bank_ctrl[b].addr  = {lane_sel,
                                (3'(b) >= pos_q[2:0]) ? row0 : row0 + 1'b1};
        end
        state_d = S_DWRITE;
      end

      // XOR the word into the banks, echo it and close the packet on its end.
      S_DWRITE: begin
        if (slot_free) begin
          for (int b = 0; b < NB; b++) begin
            bi                 = 3'(b) - pos_q[2:0];
            bank_ctrl[b].wr_en = (4'(bi) < n_q);
            bank_xor[b]        = item_masked[8*bi +: 8];
          end
          out_load = 1'b1;
          kind_d   = ifec_pkg::KindData;
          odata_d  = item_masked;
          obytes_d = n_q;
          oend_d   = item_eop_q;
          oseq_d   = '0;
          olane_d  = '0;
          ogrp_d   = '0;
          opos_d   = '0;
          ogsize_d = '0;
          olen_d   = '0;
          ocrc_d   = '0;
          state_d  = S_IDLE;
          if (!item_eop_q) begin
            crc_d = crc_new;
            pos_d = pos_new;
          end else begin
            oseq_d   = seq_q;
            olane_d  = cur_lane_q;
            ogrp_d   = grp_q[cur_lane_q];
            opos_d   = filled_q[cur_lane_q];
            ogsize_d = eff_group;
            olen_d   = pos_new;
            ocrc_d   = ~crc_new;
            seq_d    = seq_q + 32'd1;
            lng_new  = (pos_new > longest_q[cur_lane_q]) ? pos_new : longest_q[cur_lane_q];
            if ({1'b0, filled_q[cur_lane_q]} + 9'd1 >= {1'b0, eff_group}) begin
              meta_len_d              = lng_new;
              meta_lane_d             = cur_lane_q;
              meta_grp_d              = grp_q[cur_lane_q];
              parity_waiting_d        = 1'b1;
              filled_d[cur_lane_q]    = '0;
              longest_d[cur_lane_q]   = '0;
              grp_d[cur_lane_q]       = grp_q[cur_lane_q] + 16'd1;
            end else begin
              longest_d[cur_lane_q]   = lng_new;
              filled_d[cur_lane_q]    = filled_q[cur_lane_q] + 8'd1;
            end
            next_lane_d = lane_mod({1'b0, cur_lane_q} + 4'd1, eff_lanes);
            crc_d       = '1;
            pos_d       = '0;
            in_packet_d = 1'b0;
          end
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Output valid follows the load and the receiver's stall.
  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= S_CLEAR;
      clr_cnt_q        <= '0;
      in_packet_q      <= 1'b0;
      pend_data_q      <= 1'b0;
      parity_waiting_q <= 1'b0;
      meta_len_q       <= '0;
      meta_lane_q      <= '0;
      meta_grp_q       <= '0;
      next_lane_q      <= '0;
      cur_lane_q       <= '0;
      seq_q            <= '0;
      crc_q            <= '1;
      pos_q            <= '0;
      prow_q           <= '0;
      out_valid_q      <= 1'b0;
      for (int l = 0; l < NL; l++) begin
        longest_q[l] <= '0;
        filled_q[l]  <= '0;
        grp_q[l]     <= '0;
      end
    end else begin
      state_q          <= state_d;
      clr_cnt_q        <= clr_cnt_d;
      in_packet_q      <= in_packet_d;
      pend_data_q      <= pend_data_d;
      parity_waiting_q <= parity_waiting_d;
      meta_len_q       <= meta_len_d;
      meta_lane_q      <= meta_lane_d;
      meta_grp_q       <= meta_grp_d;
      next_lane_q      <= next_lane_d;
      cur_lane_q       <= cur_lane_d;
      seq_q            <= seq_d;
      crc_q            <= crc_d;
      pos_q            <= pos_d;
      prow_q           <= prow_d;
      out_valid_q      <= out_valid_d;
      longest_q        <= longest_d;
      filled_q         <= filled_d;
      grp_q            <= grp_d;
    end
  end

  // Item and output payload registers.
  always_ff @(posedge clk_i) begin
    item_data_q  <= item_data_d;
    item_bytes_q <= item_bytes_d;
    item_eop_q   <= item_eop_d;
    n_q          <= n_d;
    kind_q       <= kind_d;
    odata_q      <= odata_d;
    obytes_q     <= obytes_d;
    oend_q       <= oend_d;
    oseq_q       <= oseq_d;
    olane_q      <= olane_d;
    ogrp_q       <= ogrp_d;
    opos_q       <= opos_d;
    ogsize_q     <= ogsize_d;
    olen_q       <= olen_d;
    ocrc_q       <= ocrc_d | crc_in_data_sel;
  end

  assign out_valid_o         = out_valid_q;
  assign packet_kind_o       = kind_q;
  assign out_data_o          = odata_q;
  assign out_bytes_o         = obytes_q;
  assign packet_end_o        = oend_q;
  assign sequence_res_o      = oseq_q;
  assign lane_id_o           = olane_q;
  assign lane_group_index_o  = ogrp_q;
  assign position_in_group_o = opos_q;
  assign group_size_out_o    = ogsize_q;
  assign payload_length_o    = olen_q;
  assign payload_crc_o       = ocrc_q;

`ifndef ASSERT_OFF
  // A parity is only ever pending between packets.
  a_no_parity_in_packet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_packet_q |-> !parity_waiting_q)
    else $error("parity pending inside a packet");

  // A new packet with a pending parity first sends the parity.
  a_parity_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && op_i == ifec_pkg::OpWord && !in_packet_q && parity_waiting_q)
      |=> state_q == S_PREAD)
    else $error("data packet overtook pending parity");

  // Each packet end advances the sequence number by one.
  a_seq_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && oend_d) |=> seq_q == $past(seq_q) + 32'd1)
    else $error("sequence number did not advance on packet end");

  // No request is taken during the clearing pass.
  a_clear_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CLEAR |-> in_stall_o)
    else $error("input taken during clearing pass");
`endif

endmodule

>>> sim/testbench.sv
// Self-checking testbench for interleaved_xor_parity_fec_encoder: random and directed
// requests, a built-in lane and parity predictor, and a field-by-field check of output words.
// Depends on ifec_pkg and the encoder RTL only.
module testbench;

  localparam int unsigned Limit = 400000;

  typedef struct {
    logic        op;
    logic [63:0] data;
    logic [3:0]  cnt;
    logic        eop;
    bit          hold;
  } request_t;

  typedef struct {
    logic        kind;
    logic [63:0] data;
    logic [3:0]  bytes;
    logic        pend;
    logic [31:0] seq;
    logic [2:0]  lane;
    logic [15:0] grp;
    logic [7:0]  pos;
    logic [7:0]  gsize;
    logic [8:0]  len;
    logic [31:0] crc;
  } out_word_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic [7:0]  cfg_data_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic        op_i;
  logic [63:0] word_data_i;
  logic [3:0]  byte_count_i;
  logic        end_of_packet_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic        packet_kind_o;
  logic [63:0] out_data_o;
  logic [3:0]  out_bytes_o;
  logic        packet_end_o;
  logic [31:0] sequence_res_o;
  logic [2:0]  lane_id_o;
  logic [15:0] lane_group_index_o;
  logic [7:0]  position_in_group_o;
  logic [7:0]  group_size_out_o;
  logic [8:0]  payload_length_o;
  logic [31:0] payload_crc_o;

  interleaved_xor_parity_fec_encoder u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .op_i               (op_i),
    .word_data_i        (word_data_i),
    .byte_count_i       (byte_count_i),
    .end_of_packet_i    (end_of_packet_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .packet_kind_o      (packet_kind_o),
    .out_data_o         (out_data_o),
    .out_bytes_o        (out_bytes_o),
    .packet_end_o       (packet_end_o),
    .sequence_res_o     (sequence_res_o),
    .lane_id_o          (lane_id_o),
    .lane_group_index_o (lane_group_index_o),
    .position_in_group_o(position_in_group_o),
    .group_size_out_o   (group_size_out_o),
    .payload_length_o   (payload_length_o),
    .payload_crc_o      (payload_crc_o)
  );

  // Clock with a 20 unit period.
  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  request_t  pending_reqs[$];
  out_word_t expected_words[$];
  request_t  cur_req;
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;
  int        errors        = 0;
  int        cycles        = 0;
  int        reqs_accepted = 0;
  int        words_checked = 0;
  int        parity_words  = 0;
  bit        accepted;

  // Predictor state: configuration, lane accumulators and the pending parity packet.
  logic [3:0]  lanes_reg;
  logic [7:0]  group_reg;
  logic [63:0] lane_acc[ifec_pkg::MaxLanes][ifec_pkg::AccRows];
  int          lane_longest[ifec_pkg::MaxLanes];
  int          lane_filled[ifec_pkg::MaxLanes];
  logic [15:0] lane_groups[ifec_pkg::MaxLanes];
  int          next_lane;
  logic [31:0] seq_count;
  logic [63:0] parity_rows[ifec_pkg::AccRows];
  bit          parity_ready;
  int          parity_len;
  int          parity_lane;
  logic [15:0] parity_group;
  logic [31:0] crc_run;
  int          pkt_bytes;
  bit          in_pkt;

  function automatic int lanes_in_use();
    if (lanes_reg == 0) return 1;
    if (lanes_reg > ifec_pkg::MaxLanes) return int'(ifec_pkg::MaxLanes);
    return int'(lanes_reg);
  endfunction

  function automatic int group_in_use();
    return (group_reg == 0) ? 1 : int'(group_reg);
  endfunction

  function automatic logic [31:0] crc_update(logic [31:0] c, logic [7:0] b);
    c ^= {24'b0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ ifec_pkg::CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [63:0] low_bytes(int n);
    return (n >= 8) ? '1 : ((64'(1) << (8 * n)) - 64'(1));
  endfunction

  // Queue one expected output word; header fields are zero unless it ends a packet.
  function automatic void expect_word(logic kind, logic [63:0] d, int n, logic pend,
                                      logic [31:0] seq, int lane, logic [15:0] grp,
                                      int pos, int gsize, int len, logic [31:0] crc);
    out_word_t w;
    w.kind  = kind;
    w.data  = d;
    w.bytes = 4'(n);
    w.pend  = pend;
    w.seq   = pend ? seq : '0;
    w.lane  = pend ? 3'(lane) : '0;
    w.grp   = pend ? grp : '0;
    w.pos   = pend ? 8'(pos) : '0;
    w.gsize = pend ? 8'(gsize) : '0;
    w.len   = pend ? 9'(len) : '0;
    w.crc   = pend ? crc : '0;
    expected_words.insert(expected_words.size(), w);
  endfunction

  // Send the pending parity packet, if any, as a burst of parity words.
  function automatic void send_parity();
    int          len;
    int          words;
    int          nb;
    logic [31:0] c;
    if (!parity_ready) return;
    parity_ready = 0;
    len = (parity_len > ifec_pkg::MaxPayload) ? int'(ifec_pkg::MaxPayload) : parity_len;
    c = '1;
    for (int i = 0; i < len; i++) begin
      c = crc_update(c, parity_rows[i / 8][8 * (i % 8) +: 8]);
    end
    c = ~c;
    words = (len == 0) ? 1 : (len + 7) / 8;
    for (int w = 0; w < words; w++) begin
      nb = (len > 8 * w) ? len - 8 * w : 0;
      if (nb > 8) nb = 8;
      expect_word(ifec_pkg::KindParity, parity_rows[w] & low_bytes(nb), nb, w == words - 1,
                  seq_count, parity_lane, parity_group, 0, group_in_use(), len, c);
      if (w == words - 1) seq_count++;
    end
  endfunction

  // Work out the output words that one accepted request causes.
  function automatic void predict_request(request_t r);
    int          lane;
    int          n;
    int          off;
    logic [63:0] d;
    logic [7:0]  b;
    if (r.op == ifec_pkg::OpFlush) begin
      send_parity();
      return;
    end
    if (!in_pkt) begin
      send_parity();
      in_pkt = 1;
      if (next_lane >= lanes_in_use()) next_lane = 0;
    end
    lane = next_lane;
    n = (r.cnt > ifec_pkg::WordBytes) ? int'(ifec_pkg::WordBytes) : int'(r.cnt);
    if (n > int'(ifec_pkg::MaxPayload) - pkt_bytes) n = int'(ifec_pkg::MaxPayload) - pkt_bytes;
    d = r.data & low_bytes(n);
    for (int i = 0; i < n; i++) begin
      b = d[8 * i +: 8];
      off = pkt_bytes + i;
      crc_run = crc_update(crc_run, b);
      lane_acc[lane][off / 8][8 * (off % 8) +: 8] ^= b;
    end
    pkt_bytes += n;
    if (!r.eop) begin
      expect_word(ifec_pkg::KindData, d, n, 1'b0, '0, 0, '0, 0, 0, 0, '0);
      return;
    end
    expect_word(ifec_pkg::KindData, d, n, 1'b1, seq_count, lane, lane_groups[lane],
                lane_filled[lane], group_in_use(), pkt_bytes, ~crc_run);
    seq_count++;
    if (pkt_bytes > lane_longest[lane]) lane_longest[lane] = pkt_bytes;
    // A full group hands its accumulator over as the next parity packet.
    if (lane_filled[lane] + 1 >= group_in_use()) begin
      for (int i = 0; i < ifec_pkg::AccRows; i++) begin
        parity_rows[i] = lane_acc[lane][i];
        lane_acc[lane][i] = '0;
      end
      parity_len   = lane_longest[lane];
      parity_lane  = lane;
      parity_group = lane_groups[lane];
      parity_ready = 1;
      lane_filled[lane]  = 0;
      lane_longest[lane] = 0;
      lane_groups[lane]++;
    end else begin
      lane_filled[lane]++;
    end
    next_lane = (lane + 1) % lanes_in_use();
    crc_run   = '1;
    pkt_bytes = 0;
    in_pkt    = 0;
  endfunction

  // Request driver: presents queued requests, idling at random.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      accepted = in_valid_i && !in_stall_o;
      if (accepted) begin
        predict_request(cur_req);
        reqs_accepted++;
      end
      if (!in_valid_i || accepted) begin
        if (pending_reqs.size() > 0 && !(pending_reqs[0].hold && expected_words.size() > 0)
            && $urandom_range(99) >= send_idle_pct) begin
          cur_req = pending_reqs[0];
          pending_reqs.delete(0);
          in_valid_i      <= 1'b1;
          op_i            <= cur_req.op;
          word_data_i     <= cur_req.data;
          byte_count_i    <= cur_req.cnt;
          end_of_packet_i <= cur_req.eop;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: mismatch in %s: expected %h, actual %h", $time, name, exp_v, act_v);
      errors++;
    end
  endfunction

  // Output monitor: checks each accepted word against the oldest expectation.
  always @(posedge clk_i) begin
    out_word_t e;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected output word, expected none, actual data %h",
                   $time, out_data_o);
          errors++;
        end else begin
          e = expected_words[0];
          expected_words.delete(0);
          check_field("packet_kind", e.kind, packet_kind_o);
          check_field("out_data", e.data, out_data_o);
          check_field("out_bytes", e.bytes, out_bytes_o);
          check_field("packet_end", e.pend, packet_end_o);
          check_field("sequence_res", e.seq, sequence_res_o);
          check_field("lane_id", e.lane, lane_id_o);
          check_field("lane_group_index", e.grp, lane_group_index_o);
          check_field("position_in_group", e.pos, position_in_group_o);
          check_field("group_size_out", e.gsize, group_size_out_o);
          check_field("payload_length", e.len, payload_length_o);
          check_field("payload_crc", e.crc, payload_crc_o);
          words_checked++;
          if (e.kind == ifec_pkg::KindParity) parity_words++;
        end
      end
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > Limit) begin
      $display("testbench: errors");
      $finish;
    end
  end

  function automatic void add_word(logic [63:0] d, int cnt, bit last);
    request_t r;
    r.op   = ifec_pkg::OpWord;
    r.data = d;
    r.cnt  = 4'(cnt);
    r.eop  = last;
    r.hold = 0;
    pending_reqs.insert(pending_reqs.size(), r);
  endfunction

  function automatic void add_flush();
    request_t r;
    r.op   = ifec_pkg::OpFlush;
    r.data = {$urandom, $urandom};
    r.cnt  = 4'($urandom_range(15));
    r.eop  = 1'($urandom_range(1));
    r.hold = 0;
    pending_reqs.insert(pending_reqs.size(), r);
  endfunction

  // Random packets of random content, with flushes between and inside packets.
  function automatic void add_traffic(int target);
    int made;
    int nw;
    int cnt;
    bit last;
    made = 0;
    while (made < target) begin
      if ($urandom_range(99) < 8) begin
        add_flush();
        made++;
      end else begin
        nw = ($urandom_range(9) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 3);
        for (int w = 0; w < nw; w++) begin
          if (w > 0 && $urandom_range(29) == 0) begin
            add_flush();
            made++;
          end
          last = (w == nw - 1);
          if (last) cnt = ($urandom_range(19) == 0) ? $urandom_range(9, 15) : $urandom_range(8);
          else cnt = ($urandom_range(9) == 0) ? $urandom_range(15) : 8;
          add_word({$urandom, $urandom}, cnt, last);
          made++;
        end
      end
    end
    pending_reqs[pending_reqs.size() / 2].hold = 1;
  endfunction

  // Write both registers while the block is idle.
  task automatic set_config(int lanes, int group);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= ifec_pkg::CfgLaneCount;
    cfg_data_i <= 8'(lanes);
    lanes_reg  = 4'(lanes);
    @(posedge clk_i);
    cfg_idx_i  <= ifec_pkg::CfgGroupLength;
    cfg_data_i <= 8'(group);
    group_reg  = 8'(group);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    while (pending_reqs.size() > 0 || in_valid_i || expected_words.size() > 0) begin
      @(posedge clk_i);
    end
    repeat (12) @(posedge clk_i);
  endtask

  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = ifec_pkg::CfgLaneCount;
    cfg_data_i      = '0;
    in_valid_i      = 1'b0;
    op_i            = ifec_pkg::OpWord;
    word_data_i     = '0;
    byte_count_i    = '0;
    end_of_packet_i = 1'b0;
    out_stall_i     = 1'b0;
    lanes_reg       = 4'd1;
    group_reg       = 8'd4;
    for (int l = 0; l < ifec_pkg::MaxLanes; l++) begin
      for (int i = 0; i < ifec_pkg::AccRows; i++) lane_acc[l][i] = '0;
      lane_longest[l] = 0;
      lane_filled[l]  = 0;
      lane_groups[l]  = '0;
    end
    next_lane    = 0;
    seq_count    = '0;
    parity_ready = 0;
    parity_len   = 0;
    parity_lane  = 0;
    parity_group = '0;
    crc_run      = '1;
    pkt_bytes    = 0;
    in_pkt       = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: field extremes, empty packets, oversize counts, flushes, an overlong packet.
    send_idle_pct = 8;
    recv_idle_pct = 50;
    set_config(2, 1);
    add_word('1, 8, 1);
    add_word({$urandom, $urandom}, 0, 1);
    add_word('0, 8, 1);
    add_word('1, 8, 0);
    add_flush();
    add_word({$urandom, $urandom}, 3, 1);
    add_word({$urandom, $urandom}, 15, 1);
    add_flush();
    add_flush();
    for (int w = 0; w < 33; w++) add_word({$urandom, $urandom}, 8, w == 32);
    add_word({$urandom, $urandom}, 5, 1);
    add_flush();
    pending_reqs[pending_reqs.size() - 2].hold = 1;
    drain();

    set_config(8, 3);
    add_traffic(80);
    drain();

    send_idle_pct = 50;
    recv_idle_pct = 8;
    set_config(3, 255);
    add_traffic(100);
    drain();

    set_config(0, 2);
    add_traffic(100);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_config(12, 0);
    add_traffic(80);
    drain();

    set_config(1, 4);
    add_traffic(60);
    drain();

    $display("Covered %0d requests over six lane and group settings; checked %0d output words,",
             reqs_accepted, words_checked);
    $display("of them %0d parity words.", parity_words);
    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

>>> interleaved_xor_parity_fec_encoder.f
rtl/ifec_pkg.sv
rtl/ifec_byte_bank.sv
rtl/ifec_crc.sv
rtl/interleaved_xor_parity_fec_encoder.sv
sim/testbench.sv
